@@ design/bksm_pkg.sv @@
// Shared types, constants and operation codes for the bounded key set.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bksm_pkg;

  // Field widths of the transaction payloads.
  localparam int KEY_W    = 64;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  // Default number of key slots.
  localparam int DEF_SLOTS = 64;

  // Capacity register value after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_APPLIED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SKIPPED = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic lookup;   // register the match and free-slot vectors
    logic apply;    // update the set and load the response register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ design/bksm_ifs.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on bksm_pkg for the field widths.
`default_nettype none

interface bksm_in_if;
  import bksm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [KEY_W-1:0] key;
  logic                    last_in_batch;

  modport source (output valid, output func, output key, output last_in_batch, input ready);
  modport sink   (input valid, input func, input key, input last_in_batch, output ready);
endinterface

interface bksm_out_if;
  import bksm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                was_present;
  logic [CNT_W-1:0]    entry_count;
  logic                batch_ok;

  modport source (output valid, output status, output was_present, output entry_count,
                  output batch_ok, input ready);
  modport sink   (input valid, input status, input was_present, input entry_count,
                  input batch_ok, output ready);
endinterface

`default_nettype wire

@@ design/bksm_ctrl.sv @@
// Sequencing controller: accept, lookup, apply, with the response valid flag.
// Depends on bksm_pkg for the command struct.
`default_nettype none

module bksm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output bksm_pkg::ctrl_cmd_t      cmd
);
  import bksm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;

  // The response register can take a new result when empty or being drained.
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (rsp_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.apply) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bksm_dp.sv @@
// Datapath: key slots with parallel compare, free-slot select, count,
// batch flag, capacity register and response payload register.
// Depends on bksm_pkg for widths, codes and the command struct.
`default_nettype none

module bksm_dp #(
  parameter int SLOTS = bksm_pkg::DEF_SLOTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bksm_pkg::ctrl_cmd_t           cmd,
  input  wire logic                          cfg_we,
  input  wire logic [bksm_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic [bksm_pkg::FUNC_W-1:0]   req_func,
  input  wire logic [bksm_pkg::KEY_W-1:0]    req_key,
  input  wire logic                          req_last,
  output logic      [bksm_pkg::STATUS_W-1:0] rsp_status,
  output logic                               rsp_was_present,
  output logic      [bksm_pkg::CNT_W-1:0]    rsp_entry_count,
  output logic                               rsp_batch_ok
);
  import bksm_pkg::*;

  // Hard ceiling on the limit: capacity never exceeds the register range.
  localparam int LIM_MAX = (SLOTS > 127) ? 127 : SLOTS;

  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic              last_q;

  logic [KEY_W-1:0]  key_store [SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  match_q;
  logic [SLOTS-1:0]  free_q;
  logic [CNT_W-1:0]  key_count;
  logic              batch_failed;
  logic [CNT_W-1:0]  capacity;

  logic [SLOTS-1:0]    free_vec;
  logic [SLOTS-1:0]    free_low;
  logic [CNT_W-1:0]    limit;
  logic                present;
  logic                op_lookup;
  logic [SLOTS-1:0]    slot_valid_next;
  logic [CNT_W-1:0]    key_count_next;
  logic                fail_new;
  logic [STATUS_W-1:0] status_c;
  logic                store_we;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req_func;
      key_q  <= req_key;
      last_q <= req_last;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Lowest free slot as a one-hot vector.
  assign free_vec = ~slot_valid;
  assign free_low = free_vec & (~free_vec + SLOTS'(1));

  // Parallel compare against every valid slot, registered with the free slot.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      for (int i = 0; i < SLOTS; i++) begin
        match_q[i] <= slot_valid[i] && (key_store[i] == key_q);
      end
      free_q <= free_low;
    end
  end

  // Effective limit is the smaller of capacity and the slot count.
  assign limit = (capacity < CNT_W'(LIM_MAX)) ? capacity : CNT_W'(LIM_MAX);

  assign op_lookup = (func_q == FUNC_ADD) || (func_q == FUNC_DEL);
  assign present   = op_lookup && (|match_q);

  // Apply the operation to the set state.
  always_comb begin
    slot_valid_next = slot_valid;
    key_count_next  = key_count;
    fail_new        = batch_failed;
    status_c        = STAT_APPLIED;
    store_we        = 1'b0;
    if (batch_failed) begin
      status_c = STAT_SKIPPED;
    end else begin
      case (func_q)
        FUNC_ADD: begin
          if (!present) begin
            if ((key_count >= limit) || !(|free_q)) begin
              status_c = STAT_FULL;
              fail_new = 1'b1;
            end else begin
              slot_valid_next = slot_valid | free_q;
              key_count_next  = key_count + CNT_W'(1);
              store_we        = 1'b1;
            end
          end
        end
        FUNC_DEL: begin
          if (present) begin
            slot_valid_next = slot_valid & ~match_q;
            key_count_next  = key_count - CNT_W'(1);
          end
        end
        FUNC_CLR: begin
          slot_valid_next = '0;
          key_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Set state and batch flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      key_count    <= '0;
      batch_failed <= 1'b0;
    end else if (cmd.apply) begin
      slot_valid   <= slot_valid_next;
      key_count    <= key_count_next;
      batch_failed <= last_q ? 1'b0 : fail_new;
    end
  end

  // Key slots: a new key goes into the selected free slot.
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.apply && store_we && free_q[i]) begin
        key_store[i] <= key_q;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp_status      <= status_c;
      rsp_was_present <= present;
      rsp_entry_count <= key_count_next;
      rsp_batch_ok    <= last_q && !fail_new;
    end
  end

endmodule

`default_nettype wire

@@ design/bounded_key_set_mirror.sv @@
// Top level of the bounded key set: controller, datapath and channel ports.
// Depends on bksm_pkg, bksm_ifs, bksm_ctrl and bksm_dp.
`default_nettype none

// Bounded key set. Holds up to SLOTS distinct 64-bit keys, further limited by
// the 7-bit capacity register (reset 64); the effective limit is the smaller
// of capacity and SLOTS. Each request transaction adds a key, deletes a key
// or clears the set, and produces exactly one response transaction. Requests
// are processed one at a time: a request is accepted only in the idle state,
// and its response is loaded once the registered compare against all slots,
// together with the lowest-free-slot select, and then the apply step that
// updates the set are done. No new request is accepted until the previous
// one has been applied. The apply step waits while an earlier response is
// still held and not being taken. The response register lets the next
// request be accepted while a previous response is still waiting. Write
// capacity only while the block is idle. No clearing pass is needed after
// reset.
module bounded_key_set_mirror #(
  parameter int SLOTS = bksm_pkg::DEF_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [bksm_pkg::CNT_W-1:0] cfg_data,
  bksm_in_if.sink                         req,
  bksm_out_if.source                      rsp
);
  import bksm_pkg::*;

  ctrl_cmd_t cmd;

  bksm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  bksm_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req_func        (req.func),
    .req_key         (req.key),
    .req_last        (req.last_in_batch),
    .rsp_status      (rsp.status),
    .rsp_was_present (rsp.was_present),
    .rsp_entry_count (rsp.entry_count),
    .rsp_batch_ok    (rsp.batch_ok)
  );

endmodule

`default_nettype wire

@@ bench/bounded_key_set_mirror_tb.sv @@
// Self-checking testbench for the bounded key set: directed table, then random phases.
// Depends on bksm_pkg, the bksm_in_if / bksm_out_if channels and bounded_key_set_mirror.
`timescale 1ns / 1ps

module bounded_key_set_mirror_tb;
  import bksm_pkg::*;

  localparam int SLOTS       = DEF_SLOTS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_SIZE   = 96;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 82;

  // The fourth selector value is not an operation; the block ignores it.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam logic [KEY_W-1:0] KEY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_ALT  = 64'h5555_AAAA_5555_AAAA;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                was_present;
    logic [CNT_W-1:0]    entry_count;
    logic                batch_ok;
  } set_rsp_t;

  // One row of the directed table: either a capacity write or a request.
  // Rows with known_rsp set carry the response read straight off the spec.
  typedef struct packed {
    logic                is_cfg;
    logic [CNT_W-1:0]    cap;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic                last;
    logic                known_rsp;
    logic [STATUS_W-1:0] w_status;
    logic                w_present;
    logic [CNT_W-1:0]    w_count;
    logic                w_ok;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Empty set at reset capacity: held key, extreme keys, absent delete.
    '{1'b0, 7'd0,   FUNC_ADD, 64'd0,    1'b0, 1'b1, STAT_APPLIED, 1'b0, 7'd1, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd0,    1'b0, 1'b1, STAT_APPLIED, 1'b1, 7'd1, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, KEY_MAX,  1'b0, 1'b1, STAT_APPLIED, 1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, KEY_MIN,  1'b1, 1'b1, STAT_APPLIED, 1'b0, 7'd3, 1'b1},
    '{1'b0, 7'd0,   FUNC_DEL, KEY_ONES, 1'b1, 1'b1, STAT_APPLIED, 1'b0, 7'd3, 1'b1},
    '{1'b0, 7'd0,   FUNC_DEL, KEY_MAX,  1'b0, 1'b1, STAT_APPLIED, 1'b1, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, KEY_ALT,  1'b0, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_NOP, 64'd0,    1'b0, 1'b1, STAT_APPLIED, 1'b0, 7'd3, 1'b0},
    '{1'b0, 7'd0,   FUNC_CLR, KEY_MIN,  1'b1, 1'b1, STAT_APPLIED, 1'b0, 7'd0, 1'b1},
    '{1'b0, 7'd0,   FUNC_DEL, 64'd0,    1'b1, 1'b1, STAT_APPLIED, 1'b0, 7'd0, 1'b1},
    // Capacity two: fill, reject, skip the rest of the batch, recover.
    '{1'b1, 7'd2,   FUNC_ADD, 64'd0,    1'b0, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd1,    1'b0, 1'b1, STAT_APPLIED, 1'b0, 7'd1, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd2,    1'b0, 1'b1, STAT_APPLIED, 1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd3,    1'b0, 1'b1, STAT_FULL,    1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_DEL, 64'd1,    1'b0, 1'b1, STAT_SKIPPED, 1'b1, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_CLR, 64'd0,    1'b1, 1'b1, STAT_SKIPPED, 1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd3,    1'b1, 1'b1, STAT_FULL,    1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd2,    1'b1, 1'b1, STAT_APPLIED, 1'b1, 7'd2, 1'b1},
    // Capacity lowered below the count: held keys stay, new adds rejected.
    '{1'b1, 7'd1,   FUNC_ADD, 64'd0,    1'b0, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd4,    1'b1, 1'b1, STAT_FULL,    1'b0, 7'd2, 1'b0},
    '{1'b0, 7'd0,   FUNC_DEL, 64'd2,    1'b1, 1'b1, STAT_APPLIED, 1'b1, 7'd1, 1'b1},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd4,    1'b1, 1'b1, STAT_FULL,    1'b0, 7'd1, 1'b0},
    // Zero capacity, then the largest register value.
    '{1'b1, 7'd0,   FUNC_ADD, 64'd0,    1'b0, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_DEL, 64'd1,    1'b0, 1'b1, STAT_APPLIED, 1'b1, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, 64'd5,    1'b1, 1'b1, STAT_FULL,    1'b0, 7'd0, 1'b0},
    '{1'b1, 7'd127, FUNC_ADD, 64'd0,    1'b0, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0},
    '{1'b0, 7'd0,   FUNC_ADD, KEY_ONES, 1'b1, 1'b0, STAT_APPLIED, 1'b0, 7'd0, 1'b0}
  };

  // Capacity used in each random phase; the idle mode cycles through all four.
  localparam logic [CNT_W-1:0] PHASE_CAP [PHASES] = '{
    7'd64, 7'd127, 7'd3, 7'd0, 7'd65, 7'd63, 7'd5, 7'd64
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  bksm_in_if  req_if ();
  bksm_out_if rsp_if ();

  bounded_key_set_mirror dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // Shadow of the key set, kept in step with every accepted transaction.
  logic [KEY_W-1:0] shadow_key [SLOTS];
  logic             shadow_used [SLOTS];
  int               shadow_size;
  logic             shadow_batch_bad;
  logic [CNT_W-1:0] shadow_cap;

  set_rsp_t         pending_rsp [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               mismatches;
  int               cycle_cnt;
  int               src_gap_pct;
  int               snk_stall_pct;
  set_rsp_t         got_rsp;
  set_rsp_t         want_rsp;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one operation to the shadow set and returns the response it causes.
  function automatic set_rsp_t apply_to_shadow(input logic [FUNC_W-1:0] op,
                                               input logic [KEY_W-1:0] k,
                                               input logic last);
    set_rsp_t r;
    int       limit;
    int       hit;
    int       free_slot;
    logic     present;
    limit     = (shadow_cap < SLOTS) ? int'(shadow_cap) : SLOTS;
    hit       = -1;
    free_slot = -1;
    if (op == FUNC_ADD || op == FUNC_DEL) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && shadow_used[i] && shadow_key[i] == k) hit = i;
      end
    end
    present  = (hit >= 0);
    r.status = STAT_APPLIED;
    if (shadow_batch_bad) begin
      r.status = STAT_SKIPPED;
    end else if (op == FUNC_ADD) begin
      if (!present) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (free_slot < 0 && !shadow_used[i]) free_slot = i;
        end
        if (shadow_size >= limit || free_slot < 0) begin
          r.status         = STAT_FULL;
          shadow_batch_bad = 1'b1;
        end else begin
          shadow_used[free_slot] = 1'b1;
          shadow_key[free_slot]  = k;
          shadow_size++;
        end
      end
    end else if (op == FUNC_DEL) begin
      if (present) begin
        shadow_used[hit] = 1'b0;
        shadow_size--;
      end
    end else if (op == FUNC_CLR) begin
      for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
      shadow_size = 0;
    end
    r.was_present = present;
    r.entry_count = shadow_size[CNT_W-1:0];
    r.batch_ok    = last && !shadow_batch_bad;
    if (last) shadow_batch_bad = 1'b0;
    return r;
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    src_gap_pct   = (mode == IDLE_SRC) ? 67 : (mode == IDLE_BOTH) ? 13 : 0;
    snk_stall_pct = (mode == IDLE_SNK) ? 67 : (mode == IDLE_BOTH) ? 13 : 0;
  endtask

  // Sends one request transaction; called and returns at a falling edge.
  task automatic send_req(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic last, input logic known, input set_rsp_t known_rsp);
    set_rsp_t predicted;
    while ($urandom_range(99) < src_gap_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid         = 1'b1;
    req_if.func          = op;
    req_if.key           = k;
    req_if.last_in_batch = last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_to_shadow(op, k, last);
    pending_rsp.insert(pending_rsp.size(), known ? known_rsp : predicted);
    @(negedge clk);
  endtask

  // Drops valid, waits for every outstanding response, then lets the pipeline settle.
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    wait_drained();
    cfg_we     = 1'b1;
    cfg_data   = cap;
    shadow_cap = cap;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Response side: ready changes at the falling edge.
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Each accepted response is compared with the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got_rsp = '{rsp_if.status, rsp_if.was_present, rsp_if.entry_count, rsp_if.batch_ok};
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response transaction, got %p", $time, got_rsp);
        mismatches++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        check_field("status", int'(want_rsp.status), int'(got_rsp.status));
        check_field("was_present", int'(want_rsp.was_present), int'(got_rsp.was_present));
        check_field("entry_count", int'(want_rsp.entry_count), int'(got_rsp.entry_count));
        check_field("batch_ok", int'(want_rsp.batch_ok), int'(got_rsp.batch_ok));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[bounded_key_set_mirror] ERROR");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  k;
    int                roll;
    int                add_top;
    int                del_top;
    int                clr_top;
    set_rsp_t          row_rsp;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    req_if.valid         = 1'b0;
    req_if.func          = FUNC_ADD;
    req_if.key           = '0;
    req_if.last_in_batch = 1'b0;
    rsp_if.ready         = 1'b0;
    mismatches           = 0;
    cycle_cnt            = 0;
    shadow_size          = 0;
    shadow_batch_bad     = 1'b0;
    shadow_cap           = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = KEY_ONES;
    set_idle(IDLE_NONE);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        set_capacity(DIR_TAB[i].cap);
      end else begin
        row_rsp = '{DIR_TAB[i].w_status, DIR_TAB[i].w_present, DIR_TAB[i].w_count,
                    DIR_TAB[i].w_ok};
        send_req(DIR_TAB[i].func, DIR_TAB[i].key, DIR_TAB[i].last,
                 DIR_TAB[i].known_rsp, row_rsp);
      end
    end

    // Random phases. Large capacities get an add-heavy mix so the set fills up.
    for (int p = 0; p < PHASES; p++) begin
      set_idle(idle_mode_e'(p % 4));
      set_capacity(PHASE_CAP[p]);
      if (PHASE_CAP[p] >= 63) begin
        add_top = 82;
        del_top = 96;
        clr_top = 97;
      end else begin
        add_top = 50;
        del_top = 88;
        clr_top = 95;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < add_top) op = FUNC_ADD;
        else if (roll < del_top) op = FUNC_DEL;
        else if (roll < clr_top) op = FUNC_CLR;
        else op = FUNC_NOP;
        if ($urandom_range(9) == 0) k = {$urandom, $urandom};
        else k = key_pool[$urandom_range(POOL_SIZE - 1)];
        send_req(op, k, ($urandom_range(5) == 0), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[bounded_key_set_mirror] OK");
    end else begin
      $display("[bounded_key_set_mirror] ERROR");
    end
    $finish;
  end

endmodule
